/* hdl/brb_pkg.sv */
`timescale 1ns / 1ps
package brb_pkg;

  // default geometry
  localparam int unsigned DEPTH_DEF = 1024;
  localparam int unsigned LANES_DEF = 8;

  // fixed field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned MAX_LN  = 8;
  localparam int unsigned DATA_W  = BYTE_W * MAX_LN;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned POP_W   = 11;
  localparam int unsigned OFS_W   = 10;
  localparam int unsigned OCC_W   = 11;
  localparam int unsigned ROT_W   = 3;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_PEEK  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_e;

  // command broadcast to every bank lane
  typedef struct packed {
    logic             wr;
    logic             rd;
    logic [CNT_W-1:0] count;
    logic [ROT_W-1:0] rot;
  } lane_cmd_t;

  // per-result info for the merging stage
  typedef struct packed {
    logic             ok;
    logic             peek;
    logic [CNT_W-1:0] count;
    logic [ROT_W-1:0] rot;
  } merge_info_t;

endpackage

/* hdl/brb_lane.sv */
`timescale 1ns / 1ps
module brb_lane #(
  parameter int unsigned DEPTH = brb_pkg::DEPTH_DEF,
  parameter int unsigned BANKS = 8,
  parameter int unsigned BANK  = 0
) (
  input  logic                          clk_i,
  input  brb_pkg::lane_cmd_t            cmd_i,
  input  logic [$clog2(DEPTH)-1:0]      base_i,
  input  logic [brb_pkg::DATA_W-1:0]    write_bytes_i,
  output logic [brb_pkg::BYTE_W-1:0]    rdata_o
);
  import brb_pkg::*;

  localparam int unsigned ROWS = DEPTH / BANKS;
  localparam int unsigned RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [BYTE_W-1:0] mem_q [ROWS];
  logic [BYTE_W-1:0] rdata_q;
  logic [31:0]       step;
  logic [31:0]       idx;
  logic [RW-1:0]     row;
  logic [ROT_W-1:0]  sel;
  logic              we;
  logic [BYTE_W-1:0] wdata;

  // find which byte of the item lands in this bank, and its row
  always_comb begin
    step  = (32'(BANK) - 32'(cmd_i.rot)) & 32'(BANKS - 1);
    idx   = (32'(base_i) + step) & 32'(DEPTH - 1);
    row   = RW'(idx / BANKS);
    sel   = step[ROT_W-1:0];
    we    = cmd_i.wr && (step < 32'(cmd_i.count));
    wdata = write_bytes_i[sel*BYTE_W +: BYTE_W];
  end

  // bank storage with registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[row] <= wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[row];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/brb_merge.sv */
`timescale 1ns / 1ps
module brb_merge #(
  parameter int unsigned BANKS = 8
) (
  input  logic [BANKS-1:0][brb_pkg::BYTE_W-1:0] bank_data_i,
  input  brb_pkg::merge_info_t                  info_i,
  output logic [brb_pkg::DATA_W-1:0]            read_bytes_o
);
  import brb_pkg::*;

  localparam int unsigned BSW = (BANKS > 1) ? $clog2(BANKS) : 1;

  logic [DATA_W-1:0] rd;

  // rotate bank outputs into byte order; zero the unused bytes, and all bytes unless the result is a successful peek
  always_comb begin
    logic [31:0] src;
    rd = '0;
    for (int i = 0; i < MAX_LN; i++) begin
      src = (32'(info_i.rot) + 32'(i)) % BANKS;
      if (info_i.ok && info_i.peek && (32'(i) < 32'(info_i.count))) begin
        rd[i*BYTE_W +: BYTE_W] = bank_data_i[src[BSW-1:0]];
      end
    end
  end

  assign read_bytes_o = rd;

endmodule

/* hdl/byte_ring_buffer_core.sv */
// Latency: a result is valid the cycle after its input transfer.
// Throughput: one operation per cycle while the result side keeps ready high;
// each byte lane owns one single-ported bank, so one access per lane a cycle.
// Reset clears both pointers (buffer empty) and drops any pending result.
// Bank contents are not cleared; only written bytes are ever peeked.
`timescale 1ns / 1ps
module byte_ring_buffer_core #(
  parameter int unsigned DEPTH = brb_pkg::DEPTH_DEF,
  parameter int unsigned LANES = brb_pkg::LANES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    func_i,
  input  logic [brb_pkg::DATA_W-1:0]    write_bytes_i,
  input  logic [brb_pkg::CNT_W-1:0]     byte_count_i,
  input  logic [brb_pkg::POP_W-1:0]     pop_count_i,
  input  logic [brb_pkg::OFS_W-1:0]     start_offset_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          ok_o,
  output logic [brb_pkg::DATA_W-1:0]    read_bytes_o,
  output logic [brb_pkg::OCC_W-1:0]     occupancy_o
);
  import brb_pkg::*;

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PW    = AW + 1;
  localparam int unsigned MAXB  = (LANES < DEPTH) ? LANES : DEPTH;
  localparam int unsigned BANKS = 2 ** $clog2(MAXB);

  logic [PW-1:0]    wp_q, wp_d;
  logic [PW-1:0]    rp_q, rp_d;
  logic             out_valid_q, out_valid_d;
  merge_info_t      info_q, info_d;
  logic             in_fire;
  logic             op_ok;
  logic [31:0]      occ32;
  logic [31:0]      cnt32;
  logic [31:0]      base32;
  logic [AW-1:0]    base;
  lane_cmd_t        cmd;
  logic [BANKS-1:0][BYTE_W-1:0] bank_data;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // decide the operation and the next pointers
  always_comb begin
    occ32  = 32'(PW'(wp_q - rp_q));
    cnt32  = 32'(byte_count_i);
    op_ok  = 1'b0;
    wp_d   = wp_q;
    rp_d   = rp_q;
    base32 = 32'(wp_q);
    unique case (func_i)
      FUNC_WRITE: begin
        op_ok = (cnt32 <= LANES) && (cnt32 <= (DEPTH - occ32));
        if (op_ok) begin
          wp_d = PW'(32'(wp_q) + cnt32);
        end
      end
      FUNC_POP: begin
        op_ok = 32'(pop_count_i) <= occ32;
        if (op_ok) begin
          rp_d = PW'(32'(rp_q) + 32'(pop_count_i));
        end
      end
      FUNC_PEEK: begin
        base32 = 32'(rp_q) + 32'(start_offset_i);
        op_ok  = (cnt32 <= LANES) && (32'(start_offset_i) < occ32)
                 && ((32'(start_offset_i) + cnt32) <= occ32);
      end
      FUNC_CLEAR: begin
        op_ok = 1'b1;
        rp_d  = wp_q;
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
    base = base32[AW-1:0];

    cmd.wr    = in_fire && (func_i == FUNC_WRITE) && op_ok;
    cmd.rd    = in_fire && (func_i == FUNC_PEEK);
    cmd.count = byte_count_i;
    cmd.rot   = ROT_W'(base32 % BANKS);

    info_d.ok    = op_ok;
    info_d.peek  = (func_i == FUNC_PEEK);
    info_d.count = byte_count_i;
    info_d.rot   = cmd.rot;

    // hold a result until its transfer, then take the next one
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // pointers and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      rp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        wp_q <= wp_d;
        rp_q <= rp_d;
      end
    end
  end

  // result info, advanced on each input transfer
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      info_q <= info_d;
    end
  end

  // one bank per byte lane, the bank count rounded up to a power of two
  for (genvar b = 0; b < BANKS; b++) begin : g_lane
    brb_lane #(
      .DEPTH (DEPTH),
      .BANKS (BANKS),
      .BANK  (b)
    ) u_lane (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .base_i        (base),
      .write_bytes_i (write_bytes_i),
      .rdata_o       (bank_data[b])
    );
  end

  brb_merge #(
    .BANKS (BANKS)
  ) u_merge (
    .bank_data_i  (bank_data),
    .info_i       (info_q),
    .read_bytes_o (read_bytes_o)
  );

  logic [31:0] occ_out32;
  assign occ_out32   = 32'(PW'(wp_q - rp_q));
  assign out_valid_o = out_valid_q;
  assign ok_o        = info_q.ok;
  assign occupancy_o = occ_out32[OCC_W-1:0];

  // occupancy never exceeds the depth
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_out32 <= DEPTH)
    else $error("occupancy above depth");

  // a refused operation leaves both pointers alone
  a_refused_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !op_ok) |=> ((wp_q == $past(wp_q)) && (rp_q == $past(rp_q))))
    else $error("refused operation moved a pointer");

  // a clear empties the buffer
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (func_i == FUNC_CLEAR)) |=> (occ_out32 == 32'd0))
    else $error("clear left bytes held");

  // only a successful peek returns bytes
  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !(info_q.ok && info_q.peek)) |-> (read_bytes_o == '0))
    else $error("read bytes nonzero outside a peek");

endmodule
